[src/csu_pkg.sv]
`default_nettype none

package csu_pkg;

    // Field widths of the interface.
    localparam int TIME_W   = 48;
    localparam int PERIOD_W = 12;
    localparam int CNT_W    = 32;
    localparam int JIT_W    = 16;
    localparam int FIRE_W   = 4;

    // Default number of task slots and the number of period registers.
    localparam int CSU_NUM_TASKS = 4;
    localparam int NUM_PERIOD_REGS = 4;

    // Configuration port.
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam logic [2:0] REG_JITTER  = 3'd0;
    localparam logic [2:0] REG_PERIOD0 = 3'd1;
    localparam logic [2:0] REG_PERIOD1 = 3'd2;
    localparam logic [2:0] REG_PERIOD2 = 3'd3;
    localparam logic [2:0] REG_PERIOD3 = 3'd4;

    // Command codes.
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_WAKE  = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    // Handshake between the schedule setup sequencer and the top level.
    typedef struct packed {
        logic busy;
        logic done;
        logic ok;
    } csu_setup_status_t;

endpackage

`default_nettype wire

[src/csu_div.sv]
`default_nettype none

module csu_div (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic                           wide,
    input  wire logic [csu_pkg::TIME_W-1:0]     dividend,
    input  wire logic [csu_pkg::PERIOD_W-1:0]   divisor,
    output logic                                done,
    output logic [csu_pkg::TIME_W-1:0]          quot,
    output logic [csu_pkg::PERIOD_W-1:0]        rem
);
    import csu_pkg::*;

    localparam int SHIFT = TIME_W - PERIOD_W;
    localparam int CW = $clog2(TIME_W + 1);

    logic [TIME_W-1:0]   sh_reg, sh_next;
    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [PERIOD_W-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [PERIOD_W:0]   trial;
    logic                fits;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb begin
        trial     = {rem_reg, sh_reg[TIME_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            sh_next   = wide ? dividend : {dividend[PERIOD_W-1:0], {SHIFT{1'b0}}};
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = wide ? CW'(TIME_W) : CW'(PERIOD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? PERIOD_W'(trial - {1'b0, dvs_reg}) : trial[PERIOD_W-1:0];
            sh_next  = {sh_reg[TIME_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign quot = sh_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

[src/csu_setup.sv]
`default_nettype none

module csu_setup #(
    parameter int NUM_TASKS = csu_pkg::CSU_NUM_TASKS
) (
    input  wire logic                                           aclk,
    input  wire logic                                           aresetn,
    input  wire logic                                           launch,
    input  wire logic [NUM_TASKS-1:0][csu_pkg::PERIOD_W-1:0]    periods,
    output csu_pkg::csu_setup_status_t                          status,
    output logic [csu_pkg::PERIOD_W-1:0]                        minor_period,
    output logic [csu_pkg::TIME_W-1:0]                          frames,
    output logic [NUM_TASKS-1:0][csu_pkg::PERIOD_W-1:0]         steps
);
    import csu_pkg::*;

    localparam int CW = $clog2(NUM_TASKS + 1);
    localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_EUC    = 4'd2;
    localparam logic [3:0] S_DIVW   = 4'd3;
    localparam logic [3:0] S_MUL    = 4'd4;
    localparam logic [3:0] S_FRAMES = 4'd5;
    localparam logic [3:0] S_STEP   = 4'd6;
    localparam logic [3:0] S_DONE   = 4'd7;

    localparam logic [1:0] P_EUC  = 2'd0;
    localparam logic [1:0] P_LDIV = 2'd1;
    localparam logic [1:0] P_FPM  = 2'd2;
    localparam logic [1:0] P_STEP = 2'd3;

    logic [3:0]          state_reg, state_next;
    logic [1:0]          post_reg, post_next;
    logic                ret_l_reg, ret_l_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [PERIOD_W-1:0] g_reg, g_next;
    logic [PERIOD_W-1:0] gnew_reg, gnew_next;
    logic [TIME_W-1:0]   l_reg, l_next;
    logic [TIME_W-1:0]   ea_reg, ea_next;
    logic [PERIOD_W-1:0] eb_reg, eb_next;
    logic [TIME_W-1:0]   frames_reg, frames_next;
    logic [NUM_TASKS-1:0][PERIOD_W-1:0] step_reg, step_next;

    logic                div_start, div_wide, div_done;
    logic [TIME_W-1:0]   div_a, div_q;
    logic [PERIOD_W-1:0] div_b, div_r;
    logic [PERIOD_W-1:0] p_cur;
    logic [TIME_W+PERIOD_W-1:0] prod;

    csu_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .wide     (div_wide),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    assign p_cur = periods[i_reg[IW-1:0]];
    assign prod  = div_q * p_cur;

    // Sequencer: gcd and lcm per slot, then frame count and slot steps.
    always_comb begin
        state_next  = state_reg;
        post_next   = post_reg;
        ret_l_next  = ret_l_reg;
        i_next      = i_reg;
        g_next      = g_reg;
        gnew_next   = gnew_reg;
        l_next      = l_reg;
        ea_next     = ea_reg;
        eb_next     = eb_reg;
        frames_next = frames_reg;
        step_next   = step_reg;
        div_start   = 1'b0;
        div_wide    = 1'b0;
        div_a       = ea_reg;
        div_b       = eb_reg;
        case (state_reg)
            S_IDLE: begin
                if (launch) begin
                    i_next     = '0;
                    g_next     = '0;
                    l_next     = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_reg == CW'(NUM_TASKS)) begin
                    state_next = S_FRAMES;
                end else if (p_cur == '0) begin
                    i_next = i_reg + 1'b1;
                end else if (g_reg == '0) begin
                    g_next = p_cur;
                    l_next = TIME_W'(p_cur);
                    i_next = i_reg + 1'b1;
                end else begin
                    ea_next    = TIME_W'(g_reg);
                    eb_next    = p_cur;
                    ret_l_next = 1'b0;
                    state_next = S_EUC;
                end
            end
            S_EUC: begin
                if (eb_reg == '0) begin
                    if (!ret_l_reg) begin
                        gnew_next  = ea_reg[PERIOD_W-1:0];
                        ea_next    = l_reg;
                        eb_next    = p_cur;
                        ret_l_next = 1'b1;
                    end else begin
                        div_start  = 1'b1;
                        div_wide   = 1'b1;
                        div_a      = l_reg;
                        div_b      = ea_reg[PERIOD_W-1:0];
                        post_next  = P_LDIV;
                        state_next = S_DIVW;
                    end
                end else begin
                    div_start  = 1'b1;
                    div_wide   = ea_reg[TIME_W-1:PERIOD_W] != '0;
                    post_next  = P_EUC;
                    state_next = S_DIVW;
                end
            end
            S_DIVW: begin
                if (div_done) begin
                    case (post_reg)
                        P_EUC: begin
                            ea_next    = TIME_W'(eb_reg);
                            eb_next    = div_r;
                            state_next = S_EUC;
                        end
                        P_LDIV: begin
                            state_next = S_MUL;
                        end
                        P_FPM: begin
                            frames_next = div_q;
                            i_next      = '0;
                            state_next  = S_STEP;
                        end
                        default: begin
                            step_next[i_reg[IW-1:0]] = div_q[PERIOD_W-1:0];
                            i_next     = i_reg + 1'b1;
                            state_next = S_STEP;
                        end
                    endcase
                end
            end
            S_MUL: begin
                l_next     = prod[TIME_W-1:0];
                g_next     = gnew_reg;
                i_next     = i_reg + 1'b1;
                state_next = S_SCAN;
            end
            S_FRAMES: begin
                if (g_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    div_start  = 1'b1;
                    div_wide   = 1'b1;
                    div_a      = l_reg;
                    div_b      = g_reg;
                    post_next  = P_FPM;
                    state_next = S_DIVW;
                end
            end
            S_STEP: begin
                if (i_reg == CW'(NUM_TASKS)) begin
                    state_next = S_DONE;
                end else begin
                    div_start  = 1'b1;
                    div_a      = TIME_W'(p_cur);
                    div_b      = g_reg;
                    post_next  = P_STEP;
                    state_next = S_DIVW;
                end
            end
            S_DONE: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        post_reg   <= post_next;
        ret_l_reg  <= ret_l_next;
        i_reg      <= i_next;
        g_reg      <= g_next;
        gnew_reg   <= gnew_next;
        l_reg      <= l_next;
        ea_reg     <= ea_next;
        eb_reg     <= eb_next;
        frames_reg <= frames_next;
        step_reg   <= step_next;
    end

    assign status.busy   = state_reg != S_IDLE;
    assign status.done   = state_reg == S_DONE;
    assign status.ok     = g_reg != '0;
    assign minor_period  = g_reg;
    assign frames        = frames_reg;
    assign steps         = step_reg;

endmodule

`default_nettype wire

[src/cyclic_frame_scheduler_unit.sv]
`default_nettype none

// Channel  | Direction | Signals
// ---------+-----------+-----------------------------------------------------
// s_       | in        | s_valid, s_ready, s_cmd, s_now_ms, s_stop_at_minor
// m_       | out       | m_valid, m_ready, m_major_count ... m_missed_minor_run
// APB      | in/out    | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// A wake result appears in the output register on the next cycle. A start word
// runs the schedule setup, which uses one shared restoring divider (12 or 48
// steps per division) for the gcd, lcm, frame count and slot steps. The input
// is stalled during setup, and a wake is stalled while an untaken result holds
// the output register. Reset is synchronous and active low.
module cyclic_frame_scheduler_unit #(
    parameter int NUM_TASKS = csu_pkg::CSU_NUM_TASKS
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [1:0]                         s_cmd,
    input  wire logic [csu_pkg::TIME_W-1:0]         s_now_ms,
    input  wire logic                               s_stop_at_minor,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [csu_pkg::CNT_W-1:0]               m_major_count,
    output logic [csu_pkg::TIME_W-1:0]              m_minor_index,
    output logic                                    m_major_late,
    output logic                                    m_minor_late,
    output logic [csu_pkg::FIRE_W-1:0]              m_fire_mask,
    output logic [csu_pkg::TIME_W-1:0]              m_next_wake_ms,
    output logic                                    m_stopped,
    output logic [csu_pkg::CNT_W-1:0]               m_missed_major,
    output logic [csu_pkg::CNT_W-1:0]               m_missed_major_run,
    output logic [csu_pkg::CNT_W-1:0]               m_missed_minor,
    output logic [csu_pkg::CNT_W-1:0]               m_missed_minor_run,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [csu_pkg::APB_AW-1:0]         paddr,
    input  wire logic [csu_pkg::APB_DW-1:0]         pwdata,
    output logic [csu_pkg::APB_DW-1:0]              prdata,
    output logic                                    pready
);
    import csu_pkg::*;

    // Configuration registers.
    logic [JIT_W-1:0]    jitter_reg;
    logic [NUM_PERIOD_REGS-1:0][PERIOD_W-1:0] period_reg;
    logic [2:0]          reg_idx;
    logic                cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jitter_reg <= '0;
            period_reg <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_JITTER:  jitter_reg    <= pwdata[JIT_W-1:0];
                REG_PERIOD0: period_reg[0] <= pwdata[PERIOD_W-1:0];
                REG_PERIOD1: period_reg[1] <= pwdata[PERIOD_W-1:0];
                REG_PERIOD2: period_reg[2] <= pwdata[PERIOD_W-1:0];
                REG_PERIOD3: period_reg[3] <= pwdata[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_JITTER:  prdata = APB_DW'(jitter_reg);
            REG_PERIOD0: prdata = APB_DW'(period_reg[0]);
            REG_PERIOD1: prdata = APB_DW'(period_reg[1]);
            REG_PERIOD2: prdata = APB_DW'(period_reg[2]);
            REG_PERIOD3: prdata = APB_DW'(period_reg[3]);
            default:     prdata = '0;
        endcase
    end

    // Slot periods; slots beyond the period registers are unused.
    logic [NUM_TASKS-1:0][PERIOD_W-1:0] slot_period;
    for (genvar t = 0; t < NUM_TASKS; t++) begin : g_slot
        if (t < NUM_PERIOD_REGS) begin : g_reg
            assign slot_period[t] = period_reg[t];
        end else begin : g_zero
            assign slot_period[t] = '0;
        end
    end

    // Schedule setup.
    csu_setup_status_t                  setup_st;
    logic [PERIOD_W-1:0]                setup_minor;
    logic [TIME_W-1:0]                  setup_frames;
    logic [NUM_TASKS-1:0][PERIOD_W-1:0] setup_steps;
    logic                               launch;

    csu_setup #(.NUM_TASKS(NUM_TASKS)) u_setup (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .launch       (launch),
        .periods      (slot_period),
        .status       (setup_st),
        .minor_period (setup_minor),
        .frames       (setup_frames),
        .steps        (setup_steps)
    );

    // Run state.
    logic                running_reg, stop_pending_reg, mode_minor_reg;
    logic [PERIOD_W-1:0] minor_reg;
    logic [TIME_W-1:0]   frames_reg, pos_reg, sched_reg, start_now_reg;
    logic [CNT_W-1:0]    major_cnt_reg;
    logic [CNT_W-1:0]    mmaj_reg, mmajr_reg, mmin_reg, mminr_reg;
    logic [NUM_TASKS-1:0][PERIOD_W-1:0] step_reg, phase_reg;
    logic                m_valid_reg;

    logic                acc, wake, do_wake;
    logic [TIME_W:0]     limit, pos_inc;
    logic                late, pos_zero, pos_wrap, stop_now;
    logic [NUM_TASKS-1:0] fire;
    logic [NUM_TASKS+FIRE_W-1:0] fire_ext;

    assign s_ready = !setup_st.busy && (!m_valid_reg || m_ready || s_cmd != CMD_WAKE);
    assign acc     = s_valid && s_ready;
    assign wake    = acc && s_cmd == CMD_WAKE;
    assign do_wake = wake && running_reg;
    assign launch  = acc && s_cmd == CMD_START && !running_reg;

    // Frame checks for one wake word.
    assign limit    = {1'b0, sched_reg} + (TIME_W+1)'(jitter_reg);
    assign late     = {1'b0, s_now_ms} > limit;
    assign pos_zero = pos_reg == '0;
    assign pos_inc  = {1'b0, pos_reg} + 1'b1;
    assign pos_wrap = pos_inc >= {1'b0, frames_reg};
    assign stop_now = stop_pending_reg && (mode_minor_reg || pos_wrap);

    for (genvar t = 0; t < NUM_TASKS; t++) begin : g_fire
        assign fire[t] = step_reg[t] != '0 && phase_reg[t] == '0;
    end
    assign fire_ext = {{FIRE_W{1'b0}}, fire};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg      <= 1'b0;
            stop_pending_reg <= 1'b0;
            mode_minor_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (acc && s_cmd == CMD_STOP && running_reg) begin
                stop_pending_reg <= 1'b1;
                mode_minor_reg   <= s_stop_at_minor;
            end
            if (do_wake) begin
                m_valid_reg <= 1'b1;
                if (stop_now) begin
                    running_reg      <= 1'b0;
                    stop_pending_reg <= 1'b0;
                end
            end
            if (setup_st.done && setup_st.ok) begin
                running_reg      <= 1'b1;
                stop_pending_reg <= 1'b0;
                mode_minor_reg   <= 1'b0;
            end
        end
    end

    // Run data: committed by setup, advanced by each wake word within a run.
    always_ff @(posedge aclk) begin
        if (launch) begin
            start_now_reg <= s_now_ms;
        end
        if (setup_st.done && setup_st.ok) begin
            minor_reg     <= setup_minor;
            frames_reg    <= setup_frames;
            step_reg      <= setup_steps;
            phase_reg     <= '0;
            pos_reg       <= '0;
            sched_reg     <= start_now_reg;
            major_cnt_reg <= '0;
            mmaj_reg      <= '0;
            mmajr_reg     <= '0;
            mmin_reg      <= '0;
            mminr_reg     <= '0;
        end else if (do_wake) begin
            if (pos_zero) begin
                major_cnt_reg <= major_cnt_reg + 1'b1;
                mmaj_reg      <= late ? mmaj_reg + 1'b1 : mmaj_reg;
                mmajr_reg     <= late ? mmajr_reg + 1'b1 : '0;
            end
            mmin_reg  <= late ? mmin_reg + 1'b1 : mmin_reg;
            mminr_reg <= late ? mminr_reg + 1'b1 : '0;
            sched_reg <= sched_reg + TIME_W'(minor_reg);
            pos_reg   <= pos_wrap ? '0 : pos_inc[TIME_W-1:0];
            for (int t = 0; t < NUM_TASKS; t++) begin
                if (pos_wrap || phase_reg[t] + 1'b1 == step_reg[t]) begin
                    phase_reg[t] <= '0;
                end else begin
                    phase_reg[t] <= phase_reg[t] + 1'b1;
                end
            end
        end
    end

    // Output word register.
    always_ff @(posedge aclk) begin
        if (do_wake) begin
            m_major_count      <= pos_zero ? major_cnt_reg + 1'b1 : major_cnt_reg;
            m_minor_index      <= pos_inc[TIME_W-1:0];
            m_major_late       <= pos_zero && late;
            m_minor_late       <= late;
            m_fire_mask        <= fire_ext[FIRE_W-1:0];
            m_next_wake_ms     <= sched_reg + TIME_W'(minor_reg);
            m_stopped          <= stop_now;
            m_missed_major     <= (pos_zero && late) ? mmaj_reg + 1'b1 : mmaj_reg;
            m_missed_major_run <= pos_zero ? (late ? mmajr_reg + 1'b1 : '0) : mmajr_reg;
            m_missed_minor     <= late ? mmin_reg + 1'b1 : mmin_reg;
            m_missed_minor_run <= late ? mminr_reg + 1'b1 : '0;
        end
    end

    assign m_valid = m_valid_reg;

    // A new result word only follows an accepted wake word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) && $past(aresetn) |-> $past(s_valid && s_ready && s_cmd == CMD_WAKE))
        else $error("result word without a wake word");

    // The run only ends with a result word that reports the stop.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(running_reg) && $past(aresetn) |-> m_valid_reg && m_stopped)
        else $error("run ended without a stopped result word");

    // A pending stop exists only within a run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        stop_pending_reg |-> running_reg)
        else $error("stop pending while idle");

    // No input word is taken while the schedule setup is working.
    assert property (@(posedge aclk) disable iff (!aresetn)
        setup_st.busy |-> !s_ready)
        else $error("input accepted during setup");

endmodule

`default_nettype wire
